// ===== hw/rtl/sha1_block_compress_unit_assert.svh =====
// Assertion macros for the SHA-1 block compression unit.
// Included by the top level; no other dependencies.
`ifndef SHA1_BLOCK_COMPRESS_UNIT_ASSERT_SVH
`define SHA1_BLOCK_COMPRESS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SBC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("sha1 block compress assertion failed");
`define SBC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("sha1 block compress assertion failed");
`else
`define SBC_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define SBC_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ===== hw/rtl/sha1bc_pkg.sv =====
// Shared types and constants for the SHA-1 block compression unit.
// No dependencies.
package sha1bc_pkg;

	localparam int BLOCK_WORDS = 16;
	localparam int ADDR_W      = $clog2(BLOCK_WORDS);
	localparam int ROUNDS      = 80;
	localparam int RND_W       = $clog2(ROUNDS + 1);
	localparam int CHAIN_WORDS = 5;
	localparam int CIDX_W      = 3;

	typedef logic [31:0]         word_t;
	typedef word_t [CHAIN_WORDS-1:0] chain_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [RND_W-1:0]    rnd_t;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MSG  = 1'b1;

	localparam addr_t LAST_POS   = addr_t'(BLOCK_WORDS - 1);
	localparam rnd_t  LAST_ROUND = rnd_t'(ROUNDS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREF,
		ST_ROUND,
		ST_DONE
	} state_t;

	// control from the sequencer to the round datapath
	typedef struct packed {
		logic load;   // copy chaining words into working vars
		logic step;   // run one round
		rnd_t rnd;    // round being executed
		rnd_t rnd_rd; // round whose operands are fetched now
	} ctl_t;

	// one write port, two read ports of the schedule memory
	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		addr_t raddr_a;
		addr_t raddr_b;
	} mem_req_t;

endpackage

// ===== hw/rtl/sha1bc_sched_mem.sv =====
// Message schedule memory: 16 x 32, one write, two registered reads.
// Depends on sha1bc_pkg.
module sha1bc_sched_mem (
	input  logic                 clk,
	input  sha1bc_pkg::mem_req_t req,
	output sha1bc_pkg::word_t    rdata_a,
	output sha1bc_pkg::word_t    rdata_b
);
	import sha1bc_pkg::*;

	word_t mem [BLOCK_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[req.raddr_a];
		rdata_b <= mem[req.raddr_b];
	end

endmodule

// ===== hw/rtl/sha1bc_core.sv =====
// SHA-1 round datapath: schedule expansion, round function, working vars.
// Depends on sha1bc_pkg; pairs with sha1bc_sched_mem.
module sha1bc_core (
	input  logic                 clk,
	input  sha1bc_pkg::ctl_t     ctl,
	input  sha1bc_pkg::chain_t   h,
	input  sha1bc_pkg::word_t    rd_a,
	input  sha1bc_pkg::word_t    rd_b,
	output sha1bc_pkg::mem_req_t req,
	output sha1bc_pkg::chain_t   wv
);
	import sha1bc_pkg::*;

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	chain_t wv_q;
	word_t  wt_d1_q, wt_d2_q, wt_d3_q;  // w[t-1], w[t-2], w[t-3]
	word_t  pa_d1_q, pa_d2_q;           // port A data delayed: w[t-15], w[t-16]

	logic  is_early;
	word_t x, wt, f, k, tmp;
	word_t a, b, c, d, e;

	always_comb begin
		a = wv_q[0];
		b = wv_q[1];
		c = wv_q[2];
		d = wv_q[3];
		e = wv_q[4];
		is_early = (ctl.rnd < rnd_t'(BLOCK_WORDS));
		// port B holds w[t] early on, w[t-8] later; port A holds w[t-14]
		x  = wt_d3_q ^ rd_b ^ rd_a ^ pa_d2_q;
		wt = is_early ? rd_b : {x[30:0], x[31]};
		if (ctl.rnd < rnd_t'(20)) begin
			f = (b & c) | (~b & d);
			k = K0;
		end else if (ctl.rnd < rnd_t'(40)) begin
			f = b ^ c ^ d;
			k = K1;
		end else if (ctl.rnd < rnd_t'(60)) begin
			f = (b & c) | (b & d) | (c & d);
			k = K2;
		end else begin
			f = b ^ c ^ d;
			k = K3;
		end
		tmp = {a[26:0], a[31:27]} + f + e + k + wt;

		req.we      = ctl.step && !is_early;
		req.waddr   = ctl.rnd[ADDR_W-1:0];
		req.wdata   = wt;
		req.raddr_a = ctl.rnd_rd[ADDR_W-1:0] + addr_t'(2);
		req.raddr_b = (ctl.rnd_rd < rnd_t'(BLOCK_WORDS)) ? ctl.rnd_rd[ADDR_W-1:0]
			: ctl.rnd_rd[ADDR_W-1:0] + addr_t'(8);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			wv_q <= h;
		end else if (ctl.step) begin
			wv_q[0] <= tmp;
			wv_q[1] <= a;
			wv_q[2] <= {b[1:0], b[31:2]};
			wv_q[3] <= c;
			wv_q[4] <= d;
		end
		if (ctl.step) begin
			wt_d1_q <= wt;
			wt_d2_q <= wt_d1_q;
			wt_d3_q <= wt_d2_q;
			pa_d1_q <= rd_a;
			pa_d2_q <= pa_d1_q;
		end
	end

	assign wv = wv_q;

endmodule

// ===== hw/rtl/sha1_block_compress_unit.sv =====
// SHA-1 block compression unit, top level.
// Depends on sha1bc_pkg, sha1bc_sched_mem, sha1bc_core and the assert header.
//
// Usage:
//   Input channel (in_valid / in_stall): each word is either a chaining
//   load (req_type = 0, chain_index 0..4 selects h0..h4; other indexes are
//   dropped) or the next big-endian message word (req_type = 1).
//   Output channel (out_valid / out_stall): one word of five digest values
//   after the sixteenth message word of each block.
// Timing:
//   Loads and the first fifteen message words are taken one per cycle while
//   the input is not stalled. The sixteenth word starts a compression: an
//   operand prefetch state, 80 rounds at one per cycle, then a feed-forward
//   state that loads the digest into the output register. The round rate
//   is set by the schedule memory, read at two addresses and written at
//   one per round.
// Stalls: input is stalled while a block compresses. The digest sits in an
//   output register; a new block can be collected meanwhile, and only the
//   next feed-forward waits until the held digest is taken.
// Reset: chaining words and word position clear to zero, no digest pending.
module sha1_block_compress_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [sha1bc_pkg::CIDX_W-1:0] chain_index,
	input  sha1bc_pkg::word_t         word_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output sha1bc_pkg::word_t         digest_h0,
	output sha1bc_pkg::word_t         digest_h1,
	output sha1bc_pkg::word_t         digest_h2,
	output sha1bc_pkg::word_t         digest_h3,
	output sha1bc_pkg::word_t         digest_h4
);
	import sha1bc_pkg::*;

	state_t state_q, state_d;
	rnd_t   rnd_q;
	addr_t  wpos_q;
	chain_t h_q;
	chain_t sum;
	chain_t digest_q;
	logic   out_valid_q;

	logic     in_acc, msg_acc, out_free;
	ctl_t     ctl;
	mem_req_t core_req, mem_req;
	word_t    rd_a, rd_b;
	chain_t   wv;

	// input is taken only while collecting a block
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign msg_acc  = in_acc && (req_type == REQ_MSG);
	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl.load   = 1'b0;
		ctl.step   = 1'b0;
		ctl.rnd    = rnd_q;
		ctl.rnd_rd = rnd_t'(rnd_q + 1'b1);
		case (state_q)
			ST_IDLE: begin
				if (msg_acc && wpos_q == LAST_POS) begin
					state_d = ST_PREF;
				end
			end
			ST_PREF: begin
				ctl.load   = 1'b1;
				ctl.rnd_rd = '0;
				state_d    = ST_ROUND;
			end
			ST_ROUND: begin
				ctl.step = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// round counter and word position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q  <= '0;
			wpos_q <= '0;
		end else begin
			if (state_q == ST_PREF) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_t'(rnd_q + 1'b1);
			end
			if (msg_acc) begin
				wpos_q <= addr_t'(wpos_q + 1'b1);
			end
		end
	end

	// message words go straight into the schedule memory; rounds never overlap
	always_comb begin
		mem_req = core_req;
		if (msg_acc) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = wpos_q;
			mem_req.wdata = word_value;
		end
	end

	sha1bc_sched_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	sha1bc_core u_core (
		.clk  (clk),
		.ctl  (ctl),
		.h    (h_q),
		.rd_a (rd_a),
		.rd_b (rd_b),
		.req  (core_req),
		.wv   (wv)
	);

	// feed-forward
	always_comb begin
		for (int i = 0; i < CHAIN_WORDS; i++) begin
			sum[i] = h_q[i] + wv[i];
		end
	end

	// chaining words: loads only while idle, update at feed-forward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (state_q == ST_DONE && out_free) begin
			h_q <= sum;
		end else if (in_acc && req_type == REQ_LOAD
			&& chain_index < CIDX_W'(CHAIN_WORDS)) begin
			h_q[chain_index] <= word_value;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			digest_q <= sum;
		end
	end

	assign out_valid = out_valid_q;
	assign digest_h0 = digest_q[0];
	assign digest_h1 = digest_q[1];
	assign digest_h2 = digest_q[2];
	assign digest_h3 = digest_q[3];
	assign digest_h4 = digest_q[4];

`include "sha1_block_compress_unit_assert.svh"

	// last word of a block starts the prefetch
	`SBC_ASSERT_NEXT(a_block_start, clk, arst_n, msg_acc && wpos_q == LAST_POS, state_q == ST_PREF)
	// eighty rounds then feed-forward
	`SBC_ASSERT_NEXT(a_round_end, clk, arst_n, state_q == ST_ROUND && rnd_q == LAST_ROUND, state_q == ST_DONE)
	// word position sits at zero while a block compresses
	`SBC_ASSERT_NOW(a_wpos_idle, clk, arst_n, state_q != ST_IDLE, wpos_q == '0)
	// a finished block always presents a digest
	`SBC_ASSERT_NEXT(a_digest_out, clk, arst_n, state_q == ST_DONE && out_free, out_valid_q)

endmodule

// ===== sim/sha1_block_compress_checker.sv =====
// Checker for the SHA-1 block compression unit: watches both channels, predicts digests.
// Depends on sha1bc_pkg; instantiated beside the block by tb_sha1_block_compress_unit.
module sha1_block_compress_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          req_type,
	input  logic [sha1bc_pkg::CIDX_W-1:0] chain_index,
	input  sha1bc_pkg::word_t             word_value,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  sha1bc_pkg::word_t             digest_h0,
	input  sha1bc_pkg::word_t             digest_h1,
	input  sha1bc_pkg::word_t             digest_h2,
	input  sha1bc_pkg::word_t             digest_h3,
	input  sha1bc_pkg::word_t             digest_h4,
	output int                            fail_count,
	output int                            pending
);
	import sha1bc_pkg::*;

	typedef logic [BLOCK_WORDS-1:0][31:0] blk_t;

	localparam word_t K_CHOOSE = 32'h5a827999;
	localparam word_t K_PAR_LO = 32'h6ed9eba1;
	localparam word_t K_MAJ    = 32'h8f1bbcdc;
	localparam word_t K_PAR_HI = 32'hca62c1d6;

	chain_t hash_words;
	blk_t   blk_words;
	addr_t  blk_pos;
	chain_t digest_q[$];

	function automatic chain_t sha1_compress(chain_t h, blk_t blk);
		word_t a, b, c, d, e, f, k, wt, tmp;
		blk_t  w;
		int    t;
		w = blk;
		a = h[0];
		b = h[1];
		c = h[2];
		d = h[3];
		e = h[4];
		for (t = 0; t < ROUNDS; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
				wt = {wt[30:0], wt[31]};
				w[t % 16] = wt;
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = K_CHOOSE;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = K_PAR_LO;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PAR_HI;
			end
			tmp = {a[26:0], a[31:27]} + f + e + k + wt;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = tmp;
		end
		h[0] = h[0] + a;
		h[1] = h[1] + b;
		h[2] = h[2] + c;
		h[3] = h[3] + d;
		h[4] = h[4] + e;
		return h;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chain_t got, want;
		int     j;
		if (!arst_n) begin
			hash_words = '0;
			blk_words  = '0;
			blk_pos    = '0;
			digest_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// digest side first: a digest taken now always stems from an older block
			if (out_valid && !out_stall) begin
				got = {digest_h4, digest_h3, digest_h2, digest_h1, digest_h0};
				if (digest_q.size() == 0) begin
					$error("digest word with no expected digest: %h", got);
					fail_count++;
				end else begin
					want = digest_q.pop_front();
					for (j = 0; j < CHAIN_WORDS; j++) begin
						if (got[j] !== want[j]) begin
							$error("digest_h%0d mismatch: expected %h, actual %h",
								j, want[j], got[j]);
							fail_count++;
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (req_type == REQ_LOAD) begin
					if (chain_index < CHAIN_WORDS)
						hash_words[chain_index] = word_value;
				end else begin
					blk_words[blk_pos] = word_value;
					if (blk_pos == LAST_POS) begin
						hash_words = sha1_compress(hash_words, blk_words);
						digest_q.push_back(hash_words);
					end
					blk_pos = blk_pos + 1'b1;
				end
			end
			pending = digest_q.size();
		end
	end

endmodule

// ===== sim/tb_sha1_block_compress_unit.sv =====
// Testbench top for the SHA-1 block compression unit: clock, reset, stimulus, verdict.
// Depends on sha1bc_pkg, the block itself and sha1_block_compress_checker.
module tb_sha1_block_compress_unit;
	import sha1bc_pkg::*;

	// long receiver hold-off used to back the block up into its input
	localparam int HOLD_CYCLES  = 700;
	// extra wait once no digest is pending, as margin
	localparam int DRAIN_CYCLES = 150;
	localparam int LIMIT_CYCLES = 250000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              req_type;
	logic [CIDX_W-1:0] chain_index;
	word_t             word_value;
	logic              out_valid;
	logic              out_stall;
	word_t             digest_h0, digest_h1, digest_h2, digest_h3, digest_h4;

	int fail_count;
	int pending;

	// sender bookkeeping: position within the block and what has gone in
	int   msg_pos;
	int   words_taken;
	int   blocks_taken;
	logic idle_on;
	logic hold_off_req;

	sha1_block_compress_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.chain_index (chain_index),
		.word_value  (word_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_h0   (digest_h0),
		.digest_h1   (digest_h1),
		.digest_h2   (digest_h2),
		.digest_h3   (digest_h3),
		.digest_h4   (digest_h4)
	);

	sha1_block_compress_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.chain_index (chain_index),
		.word_value  (word_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_h0   (digest_h0),
		.digest_h1   (digest_h1),
		.digest_h2   (digest_h2),
		.digest_h3   (digest_h3),
		.digest_h4   (digest_h4),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(12 * LIMIT_CYCLES);
		$display("[sha1_block_compress_unit] ERROR");
		$finish;
	end

	// biased word values: plenty of all-zero and all-one words
	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Offer one word at the falling edge, optionally after an idle burst,
	// then hold it until a rising edge takes it (valid high, stall low).
	task automatic send_word(input logic rt, input logic [CIDX_W-1:0] idx, input word_t val);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rt;
		chain_index <= idx;
		word_value  <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (rt == REQ_MSG) begin
			words_taken++;
			msg_pos = (msg_pos + 1) % BLOCK_WORDS;
			if (msg_pos == 0)
				blocks_taken++;
		end else if (idx < CHAIN_WORDS) begin
			words_taken++;
		end
	endtask

	// Message words that close the current block, with an occasional
	// chaining load (valid or dropped index) slipped in between.
	task automatic send_block(input int load_odds);
		int n;
		n = BLOCK_WORDS - msg_pos;
		repeat (n) begin
			if (load_odds > 0 && $urandom_range(1, load_odds) == 1)
				send_word(REQ_LOAD, CIDX_W'($urandom_range(0, 7)), pick_word());
			send_word(REQ_MSG, CIDX_W'($urandom_range(0, 7)), pick_word());
		end
	endtask

	// Receiver: random stall bursts, or one long hold-off when asked for.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int j;
		in_valid     = 1'b0;
		req_type     = REQ_LOAD;
		chain_index  = '0;
		word_value   = '0;
		arst_n       = 1'b0;
		idle_on      = 1'b0;
		hold_off_req = 1'b0;
		msg_pos      = 0;
		words_taken  = 0;
		blocks_taken = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: standard initial hash, dropped loads at index extremes,
		// then the one-block message "abc" with its padding and length
		idle_on = 1'b1;
		send_word(REQ_LOAD, 3'd0, 32'h67452301);
		send_word(REQ_LOAD, 3'd1, 32'hefcdab89);
		send_word(REQ_LOAD, 3'd2, 32'h98badcfe);
		send_word(REQ_LOAD, 3'd3, 32'h10325476);
		send_word(REQ_LOAD, 3'd4, 32'hc3d2e1f0);
		send_word(REQ_LOAD, 3'd5, 32'h0000_0000);
		send_word(REQ_LOAD, 3'd7, 32'hffff_ffff);
		send_word(REQ_MSG, 3'd0, 32'h61626380);
		for (j = 1; j < 15; j++)
			send_word(REQ_MSG, 3'd0, 32'h0000_0000);
		send_word(REQ_MSG, 3'd7, 32'h0000_0018);

		// back pressure: receiver holds off while three blocks are offered,
		// so the output register fills and the block stalls its input
		hold_off_req = 1'b1;
		repeat (3) send_block(0);

		// random: mostly whole blocks with random content, some noise words
		while (words_taken < 500 || blocks_taken < 25) begin
			idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 2) == 0) begin
					for (j = 0; j < CHAIN_WORDS; j++)
						send_word(REQ_LOAD, CIDX_W'(j), pick_word());
				end
				send_block(20);
			end else begin
				repeat ($urandom_range(1, 5))
					send_word(1'($urandom_range(0, 1)), CIDX_W'($urandom_range(0, 7)),
						pick_word());
			end
		end

		// closing stretch without idling on either side
		idle_on = 1'b0;
		send_block(10);
		send_block(10);
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[sha1_block_compress_unit] OK");
		end else begin
			$display("[sha1_block_compress_unit] ERROR");
		end
		$finish;
	end

endmodule
